// File: src/clm_pkg.sv
`timescale 1ns / 1ps

package clm_pkg;

    localparam int TABLE_BITS = 8;
    localparam int N_ENTRIES  = 1 << TABLE_BITS;
    localparam int FRAC_BITS  = 16;
    localparam int EXP_BITS   = 5;
    localparam int LOG_W      = EXP_BITS + FRAC_BITS;
    localparam int MANT_W     = 32;
    localparam int CH_W       = 11;

    typedef enum logic [1:0] {
        REG_LOW  = 2'd0,
        REG_HIGH = 2'd1,
        REG_LOG  = 2'd2,
        REG_MAP  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MAP_JET  = 2'd0,
        MAP_GRAY = 2'd1,
        MAP_INV  = 2'd2
    } t_map;

    typedef enum logic [2:0] {
        CS_SORT,
        CS_LO_START,
        CS_LO_WAIT,
        CS_HI_START,
        CS_HI_WAIT,
        CS_READY
    } t_cfg_state;

    // settled configuration, seen by the sample path
    typedef struct packed {
        logic signed [31:0]  slo;
        logic signed [31:0]  shi;
        logic                log_en;
        logic [LOG_W-1:0]    llo;
        logic [LOG_W-1:0]    lhi;
        logic [1:0]          map;
    } t_cfg_view;

    // position of the highest set bit
    function automatic logic [EXP_BITS-1:0] top_bit(input logic [31:0] x);
        logic [EXP_BITS-1:0] e;
        e = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) e = EXP_BITS'(i);
        end
        return e;
    endfunction

    function automatic logic [MANT_W-1:0] normalise(input logic [31:0] x,
                                                    input logic [EXP_BITS-1:0] e);
        return MANT_W'(x << (5'd31 - e));
    endfunction

    // one squaring step: {fraction bit, new mantissa}
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] p;
        logic [MANT_W:0]     s;
        p = m * m;
        s = p[2*MANT_W-1:31];
        if (s[MANT_W]) return {1'b1, s[MANT_W:1]};
        else           return {1'b0, s[MANT_W-1:0]};
    endfunction

endpackage

// File: src/clm_log_iter.sv
`timescale 1ns / 1ps

module clm_log_iter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [31:0]               i_x,
    output logic                      o_busy,
    output logic [clm_pkg::LOG_W-1:0] o_log
);

    logic [clm_pkg::MANT_W-1:0]    r_m;
    logic [clm_pkg::EXP_BITS-1:0]  r_e;
    logic [clm_pkg::FRAC_BITS-1:0] r_f;
    logic [4:0]                    r_cnt;
    logic                          r_busy;
    logic [clm_pkg::EXP_BITS-1:0]  w_e;
    logic [clm_pkg::MANT_W:0]      w_step;

    assign w_e    = clm_pkg::top_bit(i_x);
    assign w_step = clm_pkg::sq_step(r_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(clm_pkg::FRAC_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_e <= w_e;
            r_m <= clm_pkg::normalise(i_x, w_e);
            r_f <= '0;
        end else if (r_busy) begin
            r_m <= w_step[clm_pkg::MANT_W-1:0];
            r_f <= {r_f[clm_pkg::FRAC_BITS-2:0], w_step[clm_pkg::MANT_W]};
        end
    end

    assign o_busy = r_busy;
    assign o_log  = {r_e, r_f};

endmodule

// File: src/clm_cfg.sv
`timescale 1ns / 1ps

module clm_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output clm_pkg::t_cfg_view o_view,
    output logic               o_settled
);

    logic signed [31:0]       r_low;
    logic signed [31:0]       r_high;
    logic                     r_log;
    logic [1:0]               r_map;
    logic signed [31:0]       r_slo;
    logic signed [31:0]       r_shi;
    logic                     r_log_en;
    logic [clm_pkg::LOG_W-1:0] r_llo;
    logic [clm_pkg::LOG_W-1:0] r_lhi;
    clm_pkg::t_cfg_state      r_state;
    clm_pkg::t_cfg_state      n_state;

    logic                      w_start;
    logic                      w_pick_hi;
    logic                      w_ld_lo;
    logic                      w_ld_hi;
    logic                      w_busy;
    logic [clm_pkg::LOG_W-1:0] w_log;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 32'sd0;
            r_high <= 32'sd1;
            r_log  <= 1'b0;
            r_map  <= clm_pkg::MAP_JET;
        end else if (i_cfg_valid) begin
            unique case (clm_pkg::t_reg_idx'(i_cfg_index))
                clm_pkg::REG_LOW:  r_low  <= i_cfg_data;
                clm_pkg::REG_HIGH: r_high <= i_cfg_data;
                clm_pkg::REG_LOG:  r_log  <= i_cfg_data[0];
                clm_pkg::REG_MAP:  r_map  <= i_cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= clm_pkg::CS_SORT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        if (i_cfg_valid) begin
            n_state = clm_pkg::CS_SORT;
        end else begin
            unique case (r_state)
                clm_pkg::CS_SORT:     n_state = clm_pkg::CS_LO_START;
                clm_pkg::CS_LO_START: n_state = clm_pkg::CS_LO_WAIT;
                clm_pkg::CS_LO_WAIT:  if (!w_busy) n_state = clm_pkg::CS_HI_START;
                clm_pkg::CS_HI_START: n_state = clm_pkg::CS_HI_WAIT;
                clm_pkg::CS_HI_WAIT:  if (!w_busy) n_state = clm_pkg::CS_READY;
                clm_pkg::CS_READY:    n_state = clm_pkg::CS_READY;
                default:              n_state = clm_pkg::CS_SORT;
            endcase
        end
    end

    always_comb begin
        w_start   = 1'b0;
        w_pick_hi = 1'b0;
        w_ld_lo   = 1'b0;
        w_ld_hi   = 1'b0;
        unique case (r_state)
            clm_pkg::CS_LO_START: w_start = 1'b1;
            clm_pkg::CS_LO_WAIT:  w_ld_lo = !w_busy;
            clm_pkg::CS_HI_START: begin
                w_start   = 1'b1;
                w_pick_hi = 1'b1;
            end
            clm_pkg::CS_HI_WAIT:  w_ld_hi = !w_busy;
            default: ;
        endcase
    end

    // bounds kept in order, log mode only for a positive low bound
    always_ff @(posedge i_clk) begin
        if (r_state == clm_pkg::CS_SORT) begin
            if (r_low > r_high) begin
                r_slo    <= r_high;
                r_shi    <= r_low;
                r_log_en <= r_log && (r_high > 32'sd0);
            end else begin
                r_slo    <= r_low;
                r_shi    <= r_high;
                r_log_en <= r_log && (r_low > 32'sd0);
            end
        end
        if (w_ld_lo) r_llo <= w_log;
        if (w_ld_hi) r_lhi <= w_log;
    end

    clm_log_iter u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (w_pick_hi ? r_shi : r_slo),
        .o_busy  (w_busy),
        .o_log   (w_log)
    );

    assign o_view.slo    = r_slo;
    assign o_view.shi    = r_shi;
    assign o_view.log_en = r_log_en;
    assign o_view.llo    = r_llo;
    assign o_view.lhi    = r_lhi;
    assign o_view.map    = r_map;
    assign o_settled     = (r_state == clm_pkg::CS_READY);

endmodule

// File: src/clm_log_pipe.sv
`timescale 1ns / 1ps

module clm_log_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [31:0]        i_sample,
    output logic                      o_valid,
    output logic signed [31:0]        o_sample,
    output logic [clm_pkg::LOG_W-1:0] o_log
);

    localparam int NS = clm_pkg::FRAC_BITS;

    logic                          r_v0;
    logic signed [31:0]            r_x0;
    logic                          r_v [0:NS];
    logic signed [31:0]            r_s [0:NS];
    logic [clm_pkg::EXP_BITS-1:0]  r_e [0:NS];
    logic [clm_pkg::MANT_W-1:0]    r_m [0:NS];
    logic [clm_pkg::FRAC_BITS-1:0] r_f [0:NS];
    logic [clm_pkg::EXP_BITS-1:0]  w_e;

    assign w_e = clm_pkg::top_bit(r_x0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int i = 0; i <= NS; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v[0] <= r_v0;
            for (int i = 1; i <= NS; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [clm_pkg::MANT_W:0] st;
        if (i_en) begin
            r_x0   <= i_sample;
            r_s[0] <= r_x0;
            r_e[0] <= w_e;
            r_m[0] <= clm_pkg::normalise(r_x0, w_e);
            r_f[0] <= '0;
            for (int i = 1; i <= NS; i++) begin
                st     = clm_pkg::sq_step(r_m[i-1]);
                r_s[i] <= r_s[i-1];
                r_e[i] <= r_e[i-1];
                r_m[i] <= st[clm_pkg::MANT_W-1:0];
                r_f[i] <= {r_f[i-1][clm_pkg::FRAC_BITS-2:0], st[clm_pkg::MANT_W]};
            end
        end
    end

    assign o_valid  = r_v[NS];
    assign o_sample = r_s[NS];
    assign o_log    = {r_e[NS], r_f[NS]};

endmodule

// File: src/clm_div_pipe.sv
`timescale 1ns / 1ps

module clm_div_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [31:0]                    i_num,
    input  logic [31:0]                    i_den,
    input  logic                           i_black,
    output logic                           o_valid,
    output logic [clm_pkg::TABLE_BITS-1:0] o_pos,
    output logic                           o_black
);

    localparam int TB = clm_pkg::TABLE_BITS;

    logic                r_v   [0:TB];
    logic [31:0]         r_rem [0:TB];
    logic [31:0]         r_den [0:TB];
    logic                r_sat [0:TB];
    logic                r_blk [0:TB];
    logic [TB-1:0]       r_q   [0:TB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= TB; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= TB; i++) r_v[i] <= r_v[i-1];
        end
    end

    // num >= den already means the last entry; otherwise one quotient bit per stage
    always_ff @(posedge i_clk) begin
        logic [32:0] sh;
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_sat[0] <= (i_num >= i_den);
            r_blk[0] <= i_black;
            r_q[0]   <= '0;
            for (int i = 1; i <= TB; i++) begin
                sh       = {r_rem[i-1], 1'b0};
                r_den[i] <= r_den[i-1];
                r_sat[i] <= r_sat[i-1];
                r_blk[i] <= r_blk[i-1];
                if (sh >= {1'b0, r_den[i-1]}) begin
                    r_rem[i] <= 32'(sh - {1'b0, r_den[i-1]});
                    r_q[i]   <= {r_q[i-1][TB-2:0], 1'b1};
                end else begin
                    r_rem[i] <= sh[31:0];
                    r_q[i]   <= {r_q[i-1][TB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[TB];
    assign o_pos   = r_sat[TB] ? TB'(clm_pkg::N_ENTRIES - 1) : r_q[TB];
    assign o_black = r_blk[TB];

endmodule

// File: src/scalar_colormap_lookup.sv
`timescale 1ns / 1ps

// Colour table lookup for a stream of signed 32-bit samples.
// Sample channel: i_sample_valid / o_sample_ready with i_sample; one request
// may be taken every cycle. Colour channel: o_colour_valid / i_colour_ready
// with o_red, o_green, o_blue, intensities in 1/1024 steps.
// Configuration: i_cfg_valid / o_cfg_ready, i_cfg_index selects low bound,
// high bound, log enable or map type, i_cfg_data carries the value.
// From request to colour a sample passes an input register, one normalise
// stage, 16 log squaring stages of one 32x32 multiply each, an operand stage,
// one compare stage and 8 restoring divide stages, and a colour stage.
// Throughput: one sample per cycle while the pipeline is not held, set by
// the squaring multipliers being one per stage.
// After reset and after every configuration write the bound logarithms are
// recomputed by an iterative unit; o_sample_ready stays low meanwhile.
// A configuration write is taken only once no sample request is in flight;
// while one is offered, o_sample_ready is held low.
// When the receiver stalls, one colour moves into a skid register and the
// whole pipeline then holds; nothing is lost or repeated.

module scalar_colormap_lookup (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_sample_valid,
    output logic                     o_sample_ready,
    input  logic signed [31:0]       i_sample,
    output logic                     o_colour_valid,
    input  logic                     i_colour_ready,
    output logic [clm_pkg::CH_W-1:0] o_red,
    output logic [clm_pkg::CH_W-1:0] o_green,
    output logic [clm_pkg::CH_W-1:0] o_blue,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data
);

    localparam int TB  = clm_pkg::TABLE_BITS;
    localparam int N   = clm_pkg::N_ENTRIES;
    localparam int K4W = TB + 2;
    localparam int CW  = clm_pkg::CH_W;

    clm_pkg::t_cfg_view        w_view;
    logic                      w_settled;
    logic                      w_en;
    logic                      w_take;
    logic                      w_give;
    logic                      w_cfg_take;
    logic [5:0]                r_in_flight;

    logic                      w_lp_v;
    logic signed [31:0]        w_lp_s;
    logic [clm_pkg::LOG_W-1:0] w_lp_log;

    logic                      r_nv;
    logic [31:0]               r_num;
    logic [31:0]               r_den;
    logic                      r_black;
    logic [31:0]               n_num;
    logic [31:0]               n_den;
    logic                      n_black;

    logic                      w_dv;
    logic [TB-1:0]             w_pos;
    logic                      w_dblack;

    logic                      r_out_v;
    logic [CW-1:0]             r_out_r, r_out_g, r_out_b;
    logic [CW-1:0]             n_r, n_g, n_b;
    logic                      r_skid_v;
    logic [CW-1:0]             r_skid_r, r_skid_g, r_skid_b;

    assign w_en           = !r_skid_v;
    assign o_sample_ready = w_en && w_settled && !i_cfg_valid;
    assign o_cfg_ready    = (r_in_flight == 6'd0);
    assign w_take         = i_sample_valid && o_sample_ready;
    assign w_give         = o_colour_valid && i_colour_ready;
    assign w_cfg_take     = i_cfg_valid && o_cfg_ready;

    // requests taken but not yet delivered as colours
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else if (w_take && !w_give) begin
            r_in_flight <= r_in_flight + 6'd1;
        end else if (!w_take && w_give) begin
            r_in_flight <= r_in_flight - 6'd1;
        end
    end

    clm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (w_cfg_take),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_view      (w_view),
        .o_settled   (w_settled)
    );

    clm_log_pipe u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_take),
        .i_sample (i_sample),
        .o_valid  (w_lp_v),
        .o_sample (w_lp_s),
        .o_log    (w_lp_log)
    );

    // distance above the low bound and span, in either mapping
    always_comb begin
        logic [32:0] diff;
        logic [32:0] span;
        diff    = 33'(w_lp_s) - 33'(w_view.slo);
        span    = 33'(w_view.shi) - 33'(w_view.slo);
        n_num   = '0;
        if (w_view.log_en) begin
            n_den   = 32'(w_view.lhi - w_view.llo);
            n_black = (w_view.lhi == w_view.llo);
            if (w_lp_s > 32'sd0 && w_lp_log > w_view.llo)
                n_num = 32'(w_lp_log - w_view.llo);
        end else begin
            n_den   = span[31:0];
            n_black = (w_view.slo == w_view.shi);
            if (w_lp_s > w_view.slo) n_num = diff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_nv <= 1'b0;
        else if (w_en) r_nv <= w_lp_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_black <= n_black;
        end
    end

    clm_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_nv),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_black (r_black),
        .o_valid (w_dv),
        .o_pos   (w_pos),
        .o_black (w_dblack)
    );

    always_comb begin
        logic [CW-1:0]  v;
        logic [11:0]    q;
        logic [K4W-1:0] k4;
        v  = CW'(w_pos) << (10 - TB);
        q  = 12'(w_pos) << (12 - TB);
        k4 = {w_pos, 2'b00};
        unique case (w_view.map)
            clm_pkg::MAP_GRAY: begin
                n_r = v; n_g = v; n_b = v;
            end
            clm_pkg::MAP_INV: begin
                n_r = CW'(11'd1024 - v); n_g = n_r; n_b = n_r;
            end
            default: begin
                if (k4 <= K4W'(N)) begin
                    n_r = '0; n_g = CW'(q); n_b = CW'(1024);
                end else if (k4 <= K4W'(2 * N)) begin
                    n_r = '0; n_g = CW'(1024); n_b = CW'(12'd2048 - q);
                end else if (k4 < K4W'(3 * N)) begin
                    n_r = CW'(q - 12'd2048); n_g = CW'(1024); n_b = '0;
                end else begin
                    n_r = CW'(1024); n_g = CW'(13'd4096 - 13'(q)); n_b = '0;
                end
            end
        endcase
        if (w_dblack) begin
            n_r = '0; n_g = '0; n_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_out_v <= 1'b0;
        else if (w_en) r_out_v <= w_dv;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_r <= n_r;
            r_out_g <= n_g;
            r_out_b <= n_b;
        end
    end

    // skid register takes the colour the receiver refused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_colour_ready) r_skid_v <= 1'b0;
        end else if (r_out_v && !i_colour_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_r <= r_out_r;
            r_skid_g <= r_out_g;
            r_skid_b <= r_out_b;
        end
    end

    assign o_colour_valid = r_skid_v || r_out_v;
    assign o_red          = r_skid_v ? r_skid_r : r_out_r;
    assign o_green        = r_skid_v ? r_skid_g : r_out_g;
    assign o_blue         = r_skid_v ? r_skid_b : r_out_b;

    a_no_take_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sample_ready |-> !r_skid_v)
        else $error("sample request taken while skid full");

    a_no_take_unsettled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_settled |-> !o_sample_ready)
        else $error("sample request taken during bound log recompute");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_colour_ready) |=> (r_skid_v && $stable(r_skid_r)))
        else $error("skid colour lost while stalled");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_out_v) && $stable(r_out_r)))
        else $error("output stage moved while pipeline held");

endmodule
